// ----- sv/button_press_classifier_core_macros.svh -----
// Assertion macros used by the checker of this block.
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define BPC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpc checker: property failed");

// Next-cycle implication, off during reset.
`define BPC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpc checker: property failed");

// Next-cycle implication, also checked across reset.
`define BPC_ASSERT_NXT_RAW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bpc checker: property failed");

`endif

// ----- sv/bpc_pkg.sv -----
package bpc_pkg;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 16;
   localparam int HOLD_W      = 20;
   localparam int EVENT_W     = 2;
   localparam int PHASE_W     = 2;

   typedef logic [REQ_TDATA_W-1:0] req_tdata_type;
   typedef logic [RSP_TDATA_W-1:0] rsp_tdata_type;
   typedef logic [CSR_ADDR_W-1:0]  csr_addr_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [EVENT_W-1:0]     event_type;

   localparam csr_addr_type CSR_ACTIVE_LEVEL = 2'd0;
   localparam csr_addr_type CSR_DEBOUNCE_MS  = 2'd1;
   localparam csr_addr_type CSR_LONG_MS      = 2'd2;
   localparam csr_addr_type CSR_VERY_LONG_MS = 2'd3;

   localparam event_type EV_NONE  = 2'd0;
   localparam event_type EV_SHORT = 2'd1;
   localparam event_type EV_LONG  = 2'd2;
   localparam event_type EV_VLONG = 2'd3;

   localparam logic [PHASE_W-1:0] PH_WAIT = 2'd0;
   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HELD = 2'd2;
   localparam logic [PHASE_W-1:0] PH_REL  = 2'd3;

   localparam logic                  RST_ACTIVE_LEVEL = 1'b0;
   localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_MS  = 16'd10;
   localparam logic [HOLD_W-1:0]     RST_LONG_MS      = 20'd500;
   localparam logic [HOLD_W-1:0]     RST_VERY_LONG_MS = 20'd5000;

endpackage

// ----- sv/button_press_classifier_core.sv -----
// Button press classifier. Each request transfer carries one sample of the raw
// pin level and the current millisecond time; each one yields exactly one
// response transfer with an event code (none, short, long, very long press).
// One sample is taken every cycle while req_tready is high; its response is
// registered into a two-entry output buffer, so req_tready drops only when both
// entries hold responses that the sink has not taken. The classification is a
// four-phase state machine with two 32-bit time subtractions and three compares.
// Configuration writes take effect at the next clock edge and should be made
// only while no responses are outstanding.
module button_press_classifier_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bpc_pkg::req_tdata_type req_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output bpc_pkg::rsp_tdata_type rsp_tdata,   // [1:0] event_code, [7:2] zero
   input  logic                   csr_we,
   input  bpc_pkg::csr_addr_type  csr_addr,
   input  bpc_pkg::csr_data_type  csr_wdata
);
   import bpc_pkg::*;

   logic                  active_level_ff;
   logic [DEBOUNCE_W-1:0] debounce_ms_ff;
   logic [HOLD_W-1:0]     long_ms_ff;
   logic [HOLD_W-1:0]     very_long_ms_ff;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TIME_W-1:0]  press_time_ff, press_time_in;
   logic [TIME_W-1:0]  release_time_ff, release_time_in;
   event_type          kind_ff, kind_in;

   logic      out_valid_ff, out_valid_in;
   event_type out_data_ff, out_data_in;
   logic      skid_valid_ff, skid_valid_in;
   event_type skid_data_ff, skid_data_in;

   logic              pin_level;
   logic [TIME_W-1:0] now_ms;
   logic              pressed;
   logic              accept;
   logic              out_take;
   logic [TIME_W-1:0] held_ms;
   logic [TIME_W-1:0] released_ms;
   logic              long_hit;
   logic              vlong_hit;
   logic              deb_done;
   event_type         ev;

   assign pin_level   = req_tdata[0];
   assign now_ms      = req_tdata[TIME_W:1];
   assign pressed     = (pin_level == active_level_ff);
   assign accept      = req_tvalid & req_tready;
   assign out_take    = out_valid_ff & rsp_tready;
   assign held_ms     = now_ms - press_time_ff;
   assign released_ms = now_ms - release_time_ff;
   assign long_hit    = held_ms > {{(TIME_W-HOLD_W){1'b0}}, long_ms_ff};
   assign vlong_hit   = held_ms > {{(TIME_W-HOLD_W){1'b0}}, very_long_ms_ff};
   assign deb_done    = released_ms > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms_ff};

   assign req_tready = ~skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-EVENT_W){1'b0}}, out_data_ff};

   always_comb begin
      phase_in        = phase_ff;
      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      kind_in         = kind_ff;
      ev              = EV_NONE;
      case (phase_ff)
         PH_WAIT: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
            end
         end
         PH_IDLE: begin
            if (pressed) begin
               press_time_in = now_ms;
               kind_in       = EV_NONE;
               phase_in      = PH_HELD;
            end
         end
         PH_HELD, PH_REL: begin
            if (pressed) begin
               phase_in = PH_HELD;
               if (kind_ff == EV_NONE && long_hit) begin
                  kind_in = EV_LONG;
                  ev      = EV_LONG;
               end else if (kind_ff == EV_LONG && vlong_hit) begin
                  kind_in = EV_VLONG;
                  ev      = EV_VLONG;
               end
            end else if (phase_ff == PH_HELD) begin
               release_time_in = now_ms;
               phase_in        = PH_REL;
            end else if (deb_done) begin
               if (kind_ff == EV_NONE) begin
                  kind_in = EV_SHORT;
                  ev      = EV_SHORT;
               end
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   // two-entry output buffer: skid fills only when the output entry stalls
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = ev;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = ev;
         end
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= RST_ACTIVE_LEVEL;
         debounce_ms_ff  <= RST_DEBOUNCE_MS;
         long_ms_ff      <= RST_LONG_MS;
         very_long_ms_ff <= RST_VERY_LONG_MS;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ACTIVE_LEVEL: active_level_ff <= csr_wdata[0];
            CSR_DEBOUNCE_MS:  debounce_ms_ff  <= csr_wdata[DEBOUNCE_W-1:0];
            CSR_LONG_MS:      long_ms_ff      <= csr_wdata[HOLD_W-1:0];
            CSR_VERY_LONG_MS: very_long_ms_ff <= csr_wdata[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         kind_ff  <= EV_NONE;
      end else if (accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- sv/bpc_checker.sv -----
`include "button_press_classifier_core_macros.svh"

module bpc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input bpc_pkg::rsp_tdata_type rsp_tdata
);
   import bpc_pkg::*;

   `BPC_ASSERT_NXT_RAW(a_reset_empty, reset, !rsp_tvalid)
   `BPC_ASSERT_NXT(a_accept_shows, req_tvalid && req_tready && !rsp_tvalid, rsp_tvalid)
   `BPC_ASSERT_IMP(a_full_has_out, !req_tready, rsp_tvalid)
   `BPC_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
   import bpc_pkg::*;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   req_tdata_type req_tdata  = '0;   // [0] pin_level, [32:1] now_ms, [39:33] zero
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   rsp_tdata_type rsp_tdata;         // [1:0] event_code, [7:2] zero
   logic          csr_we     = 1'b0;
   csr_addr_type  csr_addr   = CSR_ACTIVE_LEVEL;
   csr_data_type  csr_wdata  = '0;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned samples_sent  = 0;
   int unsigned error_count   = 0;
   int unsigned input_stalls  = 0;
   int unsigned events_seen [4] = '{default: 0};

   // stimulus view of the registers
   logic        cur_active   = RST_ACTIVE_LEVEL;
   int unsigned cur_debounce = 32'(RST_DEBOUNCE_MS);
   int unsigned cur_long     = 32'(RST_LONG_MS);
   int unsigned cur_vlong    = 32'(RST_VERY_LONG_MS);
   logic [31:0] wall_ms      = '0;

   // classifier shadow
   logic              pr_active;
   logic [15:0]       pr_debounce;
   logic [19:0]       pr_long;
   logic [19:0]       pr_vlong;
   logic [PHASE_W-1:0] pr_phase;
   logic [31:0]       pr_press_at;
   logic [31:0]       pr_release_at;
   event_type         pr_reported;
   event_type         expected_events [$];

   always #10 clock = ~clock;

   button_press_classifier_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic event_type hold_event(logic [31:0] t);
      logic [31:0] held;
      held = t - pr_press_at;
      if (pr_reported == EV_NONE && held > {12'b0, pr_long}) begin
         pr_reported = EV_LONG;
         return EV_LONG;
      end
      if (pr_reported == EV_LONG && held > {12'b0, pr_vlong}) begin
         pr_reported = EV_VLONG;
         return EV_VLONG;
      end
      return EV_NONE;
   endfunction

   function automatic event_type classify_sample(logic lvl, logic [31:0] t);
      logic        pressed;
      logic [31:0] released_for;
      event_type   ev;
      pressed      = (lvl == pr_active);
      released_for = t - pr_release_at;
      ev           = EV_NONE;
      case (pr_phase)
         PH_WAIT: begin
            if (!pressed) pr_phase = PH_IDLE;
         end
         PH_IDLE: begin
            if (pressed) begin
               pr_press_at = t;
               pr_reported = EV_NONE;
               pr_phase    = PH_HELD;
            end
         end
         PH_HELD: begin
            if (!pressed) begin
               pr_release_at = t;
               pr_phase      = PH_REL;
            end else begin
               ev = hold_event(t);
            end
         end
         default: begin
            if (pressed) begin
               pr_phase = PH_HELD;
               ev       = hold_event(t);
            end else if (released_for > {16'b0, pr_debounce}) begin
               if (pr_reported == EV_NONE) begin
                  pr_reported = EV_SHORT;
                  ev          = EV_SHORT;
               end
               pr_phase = PH_IDLE;
            end
         end
      endcase
      return ev;
   endfunction

   task automatic flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      event_type want;
      if (reset) begin
         pr_active     = RST_ACTIVE_LEVEL;
         pr_debounce   = RST_DEBOUNCE_MS;
         pr_long       = RST_LONG_MS;
         pr_vlong      = RST_VERY_LONG_MS;
         pr_phase      = PH_WAIT;
         pr_press_at   = '0;
         pr_release_at = '0;
         pr_reported   = EV_NONE;
         expected_events.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_ACTIVE_LEVEL: pr_active   = csr_wdata[0];
               CSR_DEBOUNCE_MS:  pr_debounce = csr_wdata[15:0];
               CSR_LONG_MS:      pr_long     = csr_wdata;
               CSR_VERY_LONG_MS: pr_vlong    = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_events.push_back(classify_sample(req_tdata[0], req_tdata[32:1]));
         if (req_tvalid && !req_tready) input_stalls++;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               flag_mismatch("response transfer with no sample pending");
            end else begin
               want = expected_events.pop_front();
               events_seen[want]++;
               if (rsp_tdata[1:0] !== want)
                  flag_mismatch($sformatf("event_code %0d, want %0d",
                                          rsp_tdata[1:0], want));
            end
         end
      end
   end

   // hold off for a long stretch on request, otherwise stall at random
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_tready  <= 1'b0;
         hold_left   <= 200;
         hold_served <= hold_served + 1;
      end else begin
         rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic send_sample(logic lvl, logic [31:0] t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, t, lvl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_addr_type addr, csr_data_type data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(csr_data_type act, csr_data_type deb,
                            csr_data_type lng, csr_data_type vlng);
      wait_idle();
      write_csr(CSR_ACTIVE_LEVEL, act);
      write_csr(CSR_DEBOUNCE_MS, deb);
      write_csr(CSR_LONG_MS, lng);
      write_csr(CSR_VERY_LONG_MS, vlng);
      csr_we       <= 1'b0;
      cur_active   = act[0];
      cur_debounce = 32'(deb[15:0]);
      cur_long     = 32'(lng);
      cur_vlong    = 32'(vlng);
   endtask

   task automatic set_pace(int unsigned idle_pct, int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic press_episode();
      int unsigned target;
      int unsigned steps;
      int unsigned k;
      logic [31:0] released_at;
      logic        prs;
      prs = cur_active;
      repeat ($urandom_range(1, 2)) begin
         wall_ms += $urandom_range(0, 5);
         send_sample(!prs, wall_ms);
      end
      case ($urandom_range(0, 2))
         0: target = $urandom_range(0, cur_long + 1);
         1: target = cur_long +
                     $urandom_range(0, (cur_vlong > cur_long ? cur_vlong - cur_long : 0) + 2);
         default: target = (cur_vlong > cur_long ? cur_vlong : cur_long) +
                           $urandom_range(1, 40);
      endcase
      steps = $urandom_range(1, 6);
      send_sample(prs, wall_ms);
      for (k = 1; k <= steps; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            // bounce back within the debounce window
            send_sample(!prs, wall_ms);
            wall_ms += $urandom_range(0, cur_debounce);
            send_sample(prs, wall_ms);
         end
         wall_ms += (k == steps) ? target - (target / steps) * (steps - 1) : target / steps;
         send_sample(prs, wall_ms);
      end
      send_sample(!prs, wall_ms);
      released_at = wall_ms;
      if ($urandom_range(0, 1)) begin
         wall_ms = released_at + cur_debounce;
         send_sample(!prs, wall_ms);
      end
      wall_ms = released_at + cur_debounce + $urandom_range(1, 20);
      send_sample(!prs, wall_ms);
   endtask

   task automatic run_random(int unsigned count);
      int unsigned goal;
      goal    = samples_sent + count;
      wall_ms = $urandom();
      while (samples_sent < goal) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(0, 1)), $urandom());
         end else begin
            press_episode();
         end
      end
   endtask

   task automatic test_first_release();
      send_sample(1'b0, 32'd0);
      send_sample(1'b1, 32'd1);
   endtask

   task automatic test_long_and_very_long();
      send_sample(1'b0, 32'd100);
      send_sample(1'b0, 32'd600);
      send_sample(1'b0, 32'd601);
      send_sample(1'b0, 32'd5101);
      send_sample(1'b1, 32'd5102);
      send_sample(1'b1, 32'd5113);
   endtask

   task automatic test_resumed_press();
      send_sample(1'b0, 32'd6000);
      send_sample(1'b1, 32'd6400);
      send_sample(1'b0, 32'd6405);
      send_sample(1'b1, 32'd6495);
      send_sample(1'b0, 32'd6505);
      send_sample(1'b1, 32'd6600);
      send_sample(1'b1, 32'd6611);
   endtask

   task automatic test_short_press();
      send_sample(1'b0, 32'd7000);
      send_sample(1'b1, 32'd7050);
      send_sample(1'b1, 32'd7060);
      send_sample(1'b1, 32'd7061);
   endtask

   task automatic test_zero_thresholds();
      configure(20'd0, 20'hF0000, 20'd0, 20'd0);
      send_sample(1'b0, 32'd8000);
      send_sample(1'b0, 32'd8000);
      send_sample(1'b0, 32'd8001);
      send_sample(1'b0, 32'd8002);
      send_sample(1'b1, 32'd8002);
      send_sample(1'b1, 32'd8003);
   endtask

   task automatic test_time_wrap();
      configure(20'hFFFFF, 20'd0, 20'd20, 20'd1000);
      send_sample(1'b1, 32'hFFFF_FFF0);
      send_sample(1'b1, 32'h0000_0005);
      send_sample(1'b0, 32'h0000_0008);
      send_sample(1'b0, 32'h0000_0009);
   endtask

   task automatic test_random_phases();
      set_pace(0, 0);
      configure(20'hFFFFE, 20'(RST_DEBOUNCE_MS), RST_LONG_MS, RST_VERY_LONG_MS);
      run_random(200);
      set_pace(55, 0);
      configure(20'd1, 20'd0, 20'd0, 20'd0);
      run_random(200);
      set_pace(0, 55);
      configure(20'd1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      run_random(200);
      set_pace(29, 29);
      configure(20'($urandom_range(0, 1)), 20'($urandom_range(0, 40)),
                20'($urandom_range(0, 300)), 20'($urandom_range(0, 900)));
      run_random(200);
      set_pace(0, 0);
      configure(20'd0, 20'd3, 20'd300, 20'd5);
      run_random(200);
      set_pace(55, 0);
      configure(20'($urandom_range(0, 1)), 20'($urandom_range(0, 40)),
                20'($urandom_range(0, 300)), 20'($urandom_range(0, 900)));
      run_random(200);
      set_pace(0, 55);
      configure(20'($urandom_range(0, 1)), 20'($urandom_range(0, 40)),
                20'($urandom_range(0, 300)), 20'($urandom_range(0, 900)));
      run_random(200);
      set_pace(29, 29);
      configure(20'($urandom_range(0, 1)), 20'($urandom_range(0, 65535)), 20'($urandom()),
                20'($urandom()));
      run_random(150);
   endtask

   task automatic test_backpressure();
      set_pace(0, 0);
      configure(20'd0, 20'd5, 20'd50, 20'd200);
      hold_requests++;
      run_random(120);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_first_release();
      test_long_and_very_long();
      test_resumed_press();
      test_short_press();
      test_zero_thresholds();
      test_time_wrap();
      test_random_phases();
      test_backpressure();
      wait_idle();
      repeat (10) @(posedge clock);
      $display("covered %0d samples: %0d short, %0d long, %0d very long, %0d quiet",
               samples_sent, events_seen[EV_SHORT], events_seen[EV_LONG],
               events_seen[EV_VLONG], events_seen[EV_NONE]);
      $display("request side stalled for %0d cycles under response backpressure",
               input_stalls);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("timeout with %0d responses outstanding", expected_events.size());
      $display("simulation failed");
      $finish;
   end

endmodule
